// ===== hw/rtl/wfd_pkg.sv =====
`default_nettype none

package wfd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    ST_IGNORED     = 3'd0,
    ST_STORED      = 3'd1,
    ST_COMPLETE    = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_TIMEOUT     = 3'd5
  } status_t;

  typedef enum logic {
    REG_MAX_FRAME_BYTES = 1'b0,
    REG_TIMEOUT_TICKS   = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  SYNC_BYTE           = 8'h00;
  localparam logic [7:0]  VERSION_BYTE        = 8'h01;
  localparam logic [15:0] VERSION_POS         = 16'd1;
  localparam logic [15:0] LEN_HI_POS          = 16'd6;
  localparam logic [15:0] LEN_LO_POS          = 16'd7;
  localparam logic [15:0] HEADER_BYTES        = 16'd8;
  localparam logic [7:0]  TICK_MAX            = 8'hFF;
  localparam logic [15:0] MAX_FRAME_BYTES_RST = 16'd2048;
  localparam logic [7:0]  TIMEOUT_TICKS_RST   = 8'd5;

  typedef struct packed {
    logic [15:0] max_frame_bytes;
    logic [7:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic [15:0] position;
    logic [15:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wfd_if.sv =====
`default_nettype none

interface wfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink (input valid, input kind, input byte_value, output ready);
endinterface

interface wfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  data_byte;
  logic [15:0] position;
  logic [15:0] frame_length;

  modport source (output valid, output status, output data_byte, output position,
                  output frame_length, input ready);
  modport sink (input valid, input status, input data_byte, input position,
                input frame_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wfd_cfg_regs.sv =====
`default_nettype none

module wfd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output wfd_pkg::cfg_t cfg
);

  logic [15:0]       max_frame_bytes_r;
  logic [7:0]        timeout_ticks_r;
  logic              wr_en;
  wfd_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = wfd_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_bytes_r <= wfd_pkg::MAX_FRAME_BYTES_RST;
      timeout_ticks_r   <= wfd_pkg::TIMEOUT_TICKS_RST;
    end else if (wr_en) begin
      unique case (idx)
        wfd_pkg::REG_MAX_FRAME_BYTES: max_frame_bytes_r <= pwdata[15:0];
        wfd_pkg::REG_TIMEOUT_TICKS:   timeout_ticks_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      wfd_pkg::REG_MAX_FRAME_BYTES: prdata = {16'd0, max_frame_bytes_r};
      wfd_pkg::REG_TIMEOUT_TICKS:   prdata = {24'd0, timeout_ticks_r};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg.max_frame_bytes = max_frame_bytes_r;
  assign cfg.timeout_ticks   = timeout_ticks_r;

endmodule

`default_nettype wire

// ===== hw/rtl/wfd_parser.sv =====
`default_nettype none

module wfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             kind,
  input  logic [7:0]       byte_value,
  input  wfd_pkg::cfg_t    cfg,
  output wfd_pkg::result_t res
);

  wfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] payload_length_r, payload_length_nxt;
  logic [7:0]  elapsed_r, elapsed_nxt;
  logic [7:0]  elapsed_inc;
  logic [15:0] full_len;
  logic [16:0] frame_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= wfd_pkg::PH_IDLE;
      byte_index_r     <= 16'd0;
      payload_length_r <= 16'd0;
      elapsed_r        <= 8'd0;
    end else if (step_en) begin
      phase_r          <= phase_nxt;
      byte_index_r     <= byte_index_nxt;
      payload_length_r <= payload_length_nxt;
      elapsed_r        <= elapsed_nxt;
    end
  end

  assign elapsed_inc = (elapsed_r == wfd_pkg::TICK_MAX) ? elapsed_r : elapsed_r + 8'd1;
  assign full_len    = {payload_length_r[15:8], byte_value};
  assign frame_total = {1'b0, full_len} + {1'b0, wfd_pkg::HEADER_BYTES};

  always_comb begin
    phase_nxt          = phase_r;
    byte_index_nxt     = byte_index_r;
    payload_length_nxt = payload_length_r;
    elapsed_nxt        = elapsed_r;
    res.status         = wfd_pkg::ST_IGNORED;
    res.data_byte      = 8'd0;
    res.position       = 16'd0;
    res.frame_length   = 16'd0;

    if (kind) begin
      if (phase_r != wfd_pkg::PH_IDLE) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > cfg.timeout_ticks) begin
          phase_nxt          = wfd_pkg::PH_IDLE;
          byte_index_nxt     = 16'd0;
          payload_length_nxt = 16'd0;
          elapsed_nxt        = 8'd0;
          res.status         = wfd_pkg::ST_TIMEOUT;
        end
      end
    end else begin
      unique case (phase_r)
        wfd_pkg::PH_IDLE: begin
          if (byte_value == wfd_pkg::SYNC_BYTE) begin
            phase_nxt          = wfd_pkg::PH_HEADER;
            byte_index_nxt     = 16'd1;
            payload_length_nxt = 16'd0;
            elapsed_nxt        = 8'd0;
            res.status         = wfd_pkg::ST_STORED;
            res.data_byte      = byte_value;
          end
        end
        wfd_pkg::PH_HEADER: begin
          res.status     = wfd_pkg::ST_STORED;
          res.data_byte  = byte_value;
          res.position   = byte_index_r;
          byte_index_nxt = byte_index_r + 16'd1;
          if (byte_index_r == wfd_pkg::VERSION_POS) begin
            if (byte_value != wfd_pkg::VERSION_BYTE) begin
              phase_nxt      = wfd_pkg::PH_IDLE;
              byte_index_nxt = 16'd0;
              elapsed_nxt    = 8'd0;
              res.status     = wfd_pkg::ST_BAD_VERSION;
            end
          end else if (byte_index_r == wfd_pkg::LEN_HI_POS) begin
            payload_length_nxt = {byte_value, 8'd0};
          end else if (byte_index_r == wfd_pkg::LEN_LO_POS) begin
            if (frame_total > {1'b0, cfg.max_frame_bytes}) begin
              phase_nxt          = wfd_pkg::PH_IDLE;
              byte_index_nxt     = 16'd0;
              payload_length_nxt = 16'd0;
              elapsed_nxt        = 8'd0;
              res.status         = wfd_pkg::ST_TOO_LONG;
            end else if (full_len == 16'd0) begin
              phase_nxt          = wfd_pkg::PH_IDLE;
              byte_index_nxt     = 16'd0;
              payload_length_nxt = 16'd0;
              elapsed_nxt        = 8'd0;
              res.status         = wfd_pkg::ST_COMPLETE;
              res.frame_length   = wfd_pkg::HEADER_BYTES;
            end else begin
              phase_nxt          = wfd_pkg::PH_DATA;
              payload_length_nxt = full_len;
            end
          end
        end
        wfd_pkg::PH_DATA: begin
          res.status    = wfd_pkg::ST_STORED;
          res.data_byte = byte_value;
          res.position  = byte_index_r;
          if (byte_index_r == payload_length_r + wfd_pkg::LEN_LO_POS) begin
            phase_nxt          = wfd_pkg::PH_IDLE;
            byte_index_nxt     = 16'd0;
            payload_length_nxt = 16'd0;
            elapsed_nxt        = 8'd0;
            res.status         = wfd_pkg::ST_COMPLETE;
            res.frame_length   = payload_length_r + wfd_pkg::HEADER_BYTES;
          end else begin
            byte_index_nxt = byte_index_r + 16'd1;
          end
        end
        default: begin
          phase_nxt          = wfd_pkg::PH_IDLE;
          byte_index_nxt     = 16'd0;
          payload_length_nxt = 16'd0;
          elapsed_nxt        = 8'd0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wfd_pkg::PH_IDLE |->
      byte_index_r == 16'd0 && payload_length_r == 16'd0 && elapsed_r == 8'd0)
    else $error("idle state not cleared");

  a_header_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wfd_pkg::PH_HEADER |->
      byte_index_r >= 16'd1 && byte_index_r <= wfd_pkg::LEN_LO_POS)
    else $error("header index out of range");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wfd_pkg::PH_DATA |->
      payload_length_r != 16'd0 && byte_index_r >= wfd_pkg::HEADER_BYTES &&
      byte_index_r <= payload_length_r + wfd_pkg::LEN_LO_POS)
    else $error("data phase index or length inconsistent");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/wfd_out_stage.sv =====
`default_nettype none

module wfd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  wfd_pkg::result_t res,
  input  logic             out_ready,
  output logic             take_ok,
  output logic             out_valid,
  output wfd_pkg::result_t out_res
);

  logic             out_valid_r, out_valid_nxt;
  wfd_pkg::result_t res_r;

  assign take_ok       = !out_valid_r || out_ready;
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef NO_ASSERTIONS
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded result not presented");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !take_ok |-> out_valid_r && !load)
    else $error("stall without pending result");

  a_len_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status != wfd_pkg::ST_COMPLETE |-> res_r.frame_length == 16'd0)
    else $error("frame length outside completion");

  a_complete_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status == wfd_pkg::ST_COMPLETE |->
      res_r.frame_length >= wfd_pkg::HEADER_BYTES)
    else $error("completed frame shorter than header");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/wrapper_frame_deframer.sv =====
`default_nettype none

// Channel  | Direction | Payload                                        | Handshake
// in_ch    | in        | kind, byte_value                               | valid/ready
// out_ch   | out       | status, data_byte, position, frame_length      | valid/ready
// cfg_*    | in        | max_frame_bytes (0x0), timeout_ticks (0x4)     | APB, pready high
//
// One transaction in, one transaction out; a new input is taken every cycle unless a result waits unread.
// The parser state and the result register update at acceptance; the result shows in the cycle after.
// The result register parts the channels; in_ch stalls only while a result waits unread.
// Synchronous active-low reset returns the parser to idle and config registers to defaults.

module wrapper_frame_deframer (
  input  logic         clk,
  input  logic         rst_n,
  wfd_in_if.sink       in_ch,
  wfd_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  wfd_pkg::cfg_t    cfg;
  wfd_pkg::result_t step_res;
  wfd_pkg::result_t out_res;
  logic             take_ok;
  logic             accept;
  logic             out_valid;

  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;

  wfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  wfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (accept),
    .kind       (in_ch.kind),
    .byte_value (in_ch.byte_value),
    .cfg        (cfg),
    .res        (step_res)
  );

  wfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (step_res),
    .out_ready (out_ch.ready),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_res.status;
  assign out_ch.data_byte    = out_res.data_byte;
  assign out_ch.position     = out_res.position;
  assign out_ch.frame_length = out_res.frame_length;

endmodule

`default_nettype wire
